// ===== src/b64se_pkg.sv =====
`default_nettype none

package b64se_pkg;

    // Character constants of the standard alphabet.
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_SLASH   = 8'h2F;
    localparam logic [7:0] CHAR_PAD     = 8'h3D;

    // Default number of encoded groups that can wait between front and back.
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] char_out;
        logic       last_char;
    } out_item_t;

    // Position within the three-byte group.
    typedef enum logic [1:0] {
        GRP_START,
        GRP_ONE,
        GRP_TWO
    } grp_pos_t;

    // One run of characters: four sextets, the index of the last data
    // character and the index of the last character including padding.
    typedef struct packed {
        logic [3:0][5:0] sextet;
        logic [1:0]      last_data_idx;
        logic [1:0]      last_idx;
    } job_t;

    function automatic logic [7:0] b64_char(input logic [5:0] v);
        logic [7:0] ch;
        if (v < 6'd26) begin
            ch = CHAR_UPPER_A + {2'b00, v};
        end else if (v < 6'd52) begin
            ch = CHAR_LOWER_A + {2'b00, v - 6'd26};
        end else if (v < 6'd62) begin
            ch = CHAR_DIGIT_0 + {2'b00, v - 6'd52};
        end else if (v == 6'd62) begin
            ch = CHAR_PLUS;
        end else begin
            ch = CHAR_SLASH;
        end
        return ch;
    endfunction

endpackage

`default_nettype wire

// ===== src/b64se_front.sv =====
`default_nettype none

module b64se_front
    import b64se_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire in_item_t in_data,
    input  wire logic     cfg_write_en,
    input  wire logic     cfg_write_data,
    input  wire logic     q_full,
    output logic          job_push,
    output job_t          job
);

    grp_pos_t   pos_reg, pos_next;
    logic [7:0] held_first_reg, held_first_next;
    logic [7:0] held_second_reg, held_second_next;
    logic       pad_enable_reg;
    logic       accept;
    logic [7:0] b;
    logic [7:0] c0;
    logic [7:0] c1;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign b        = in_data.data_byte;
    assign c0       = held_first_reg;
    assign c1       = held_second_reg;

    // Next state: hold bytes until the group completes or the message ends.
    always_comb
    begin
        pos_next         = pos_reg;
        held_first_next  = held_first_reg;
        held_second_next = held_second_reg;
        if (accept)
        begin
            unique case (pos_reg)
                GRP_ONE:
                begin
                    held_second_next = b;
                    pos_next = in_data.last_byte ? GRP_START : GRP_TWO;
                end
                GRP_TWO:
                begin
                    pos_next = GRP_START;
                end
                default:
                begin
                    held_first_next = b;
                    pos_next = in_data.last_byte ? GRP_START : GRP_ONE;
                end
            endcase
        end
    end

    // Outputs: the run of sextets for the queue.
    always_comb
    begin
        job_push = 1'b0;
        job      = '0;
        unique case (pos_reg)
            GRP_ONE:
            begin
                job_push           = accept && in_data.last_byte;
                job.sextet[0]      = c0[7:2];
                job.sextet[1]      = {c0[1:0], b[7:4]};
                job.sextet[2]      = {b[3:0], 2'b00};
                job.last_data_idx  = 2'd2;
                job.last_idx       = pad_enable_reg ? 2'd3 : 2'd2;
            end
            GRP_TWO:
            begin
                job_push           = accept;
                job.sextet[0]      = c0[7:2];
                job.sextet[1]      = {c0[1:0], c1[7:4]};
                job.sextet[2]      = {c1[3:0], b[7:6]};
                job.sextet[3]      = b[5:0];
                job.last_data_idx  = 2'd3;
                job.last_idx       = 2'd3;
            end
            default:
            begin
                job_push           = accept && in_data.last_byte;
                job.sextet[0]      = b[7:2];
                job.sextet[1]      = {b[1:0], 4'b0000};
                job.last_data_idx  = 2'd1;
                job.last_idx       = pad_enable_reg ? 2'd3 : 2'd1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= GRP_START;
            pad_enable_reg <= 1'b1;
        end
        else
        begin
            pos_reg <= pos_next;
            if (cfg_write_en)
            begin
                pad_enable_reg <= cfg_write_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        held_first_reg  <= held_first_next;
        held_second_reg <= held_second_next;
    end

endmodule

`default_nettype wire

// ===== src/b64se_queue.sv =====
`default_nettype none

module b64se_queue
    import b64se_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire job_t push_job,
    output logic      full,
    input  wire logic pop,
    output logic      q_valid,
    output job_t      q_job
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_job   = store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= push_job;
        end
    end

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue written while full");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_valid)
        else $error("queue read while empty");

    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

endmodule

`default_nettype wire

// ===== src/b64se_back.sv =====
`default_nettype none

module b64se_back
    import b64se_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic q_valid,
    input  wire job_t q_job,
    output logic      pop,
    output logic      out_valid,
    input  wire logic out_ready,
    output out_item_t out_data
);

    job_t       cur_job_reg, cur_job_next;
    logic       cur_valid_reg, cur_valid_next;
    logic [1:0] idx_reg, idx_next;
    logic       out_valid_reg, out_valid_next;
    out_item_t  out_data_reg, out_data_next;
    logic       load_out;
    logic       cur_is_last;

    assign out_valid   = out_valid_reg;
    assign out_data    = out_data_reg;
    assign load_out    = !out_valid_reg || out_ready;
    assign cur_is_last = (idx_reg == cur_job_reg.last_idx);
    assign pop         = q_valid && (!cur_valid_reg || (load_out && cur_is_last));

    always_comb
    begin
        cur_job_next   = cur_job_reg;
        cur_valid_next = cur_valid_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (load_out)
        begin
            out_valid_next = cur_valid_reg;
            if (cur_valid_reg)
            begin
                out_data_next.char_out  = (idx_reg > cur_job_reg.last_data_idx)
                                        ? CHAR_PAD
                                        : b64_char(cur_job_reg.sextet[idx_reg]);
                out_data_next.last_char = cur_is_last;
                idx_next = idx_reg + 1'b1;
                if (cur_is_last)
                begin
                    cur_valid_next = 1'b0;
                end
            end
        end
        if (pop)
        begin
            cur_job_next   = q_job;
            cur_valid_next = 1'b1;
            idx_next       = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_job_reg  <= cur_job_next;
        out_data_reg <= out_data_next;
    end

    a_idx_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg |-> (idx_reg <= cur_job_reg.last_idx))
        else $error("character index beyond end of run");

    a_emit_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (load_out && cur_valid_reg) |=> out_valid_reg)
        else $error("character produced but output not valid");

    a_pop_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && cur_valid_reg) |-> (load_out && cur_is_last))
        else $error("run replaced before its last character was sent");

endmodule

`default_nettype wire

// ===== src/base64_stream_encoder.sv =====
// Streaming Base64 encoder with the standard alphabet.
// Input channel (in_valid, in_ready, in_data): one raw byte per item, with
// last_byte marking the final byte of a message. Output channel (out_valid,
// out_ready, out_data): one ASCII character per item, with last_char marking
// the final character of each run. Every third byte of a group gives a run of
// four characters; a message ending on a partial group gives two or three
// characters, filled to four with '=' when pad_enable is set.
// The configuration port writes pad_enable whenever cfg_write_en is high;
// it should only be changed while the encoder is idle.
// The run for a closed group is written into the queue, then loaded into the
// back stage and then into the output register. The output side sends one
// character per cycle while the receiver is ready, and an input item may be
// accepted in every cycle while the queue has room.
// A front stage groups bytes and builds runs, a small queue holds the runs,
// and a back stage serialises them into characters through an output register.
// Reset clears the group position, empties the queue and sets pad_enable.
// When the receiver stalls, the output register holds its item, the queue
// fills, and in_ready drops once the queue is full.
`default_nettype none

module base64_stream_encoder
    import b64se_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire in_item_t in_data,
    output logic          out_valid,
    input  wire logic     out_ready,
    output out_item_t     out_data,
    input  wire logic     cfg_write_en,
    input  wire logic     cfg_write_data
);

    // Runs passed from the front stage into the queue.
    logic job_push;
    job_t job;
    logic q_full;

    // Runs passed from the queue to the serialiser.
    logic q_valid;
    logic q_pop;
    job_t q_job;

    b64se_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_data        (in_data),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .q_full         (q_full),
        .job_push       (job_push),
        .job            (job)
    );

    b64se_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (job_push),
        .push_job (job),
        .full     (q_full),
        .pop      (q_pop),
        .q_valid  (q_valid),
        .q_job    (q_job)
    );

    b64se_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_job     (q_job),
        .pop       (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

// ===== verif/base64_stream_encoder_test.sv =====
`default_nettype none

module base64_stream_encoder_test
    import b64se_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // The run is stopped here if the encoder hangs. The slowest correct run
    // has about 450 bytes and at most four characters per byte.
    localparam int CYCLE_LIMIT   = 200000;
    // Cycles allowed after the last expected character before the encoder
    // counts as idle.
    localparam int SETTLE_CYCLES = 4;
    localparam int END_CYCLES    = 10;
    localparam int IDLE_PERCENT  = 33;

    // The standard alphabet, first character in the top byte, so that
    // sextet value v sits at bits [8*(63-v) +: 8].
    localparam logic [511:0] BASE64_ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    logic      clk;
    logic      rst_n          = 1'b0;
    logic      in_valid       = 1'b0;
    logic      in_ready;
    in_item_t  in_data        = '0;
    logic      out_valid;
    logic      out_ready      = 1'b0;
    out_item_t out_data;
    logic      cfg_write_en   = 1'b0;
    logic      cfg_write_data = 1'b0;

    // Our own copy of the encoder's state. It follows the encoder at every
    // accepted item and at every write of the padding register.
    logic      pad_en      = 1'b1;
    logic [7:0] held_first  = 8'h00;
    logic [7:0] held_second = 8'h00;
    grp_pos_t  group_pos   = GRP_START;

    // Characters still owed by the encoder, oldest first.
    out_item_t expected_chars[$];

    // These switch the random gaps on each side of the encoder on or off.
    bit sender_idles   = 1'b1;
    bit receiver_stalls = 1'b1;
    // The test sequence sets this to ask the receiver for a long hold-off.
    // The receiver takes the request over, then counts the hold-off down
    // itself.
    int hold_request   = 0;

    int mismatch_count = 0;
    int bytes_sent     = 0;
    int messages_sent  = 0;
    int chars_checked  = 0;
    int input_stalls   = 0;
    int cycle_count    = 0;

    base64_stream_encoder u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_data        (in_data),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_data       (out_data),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Character predictor
    // ------------------------------------------------------------------

    function automatic logic [7:0] sextet_char(input logic [5:0] v);
        return BASE64_ALPHABET[8 * (63 - v) +: 8];
    endfunction

    function automatic void owe_char(input logic [7:0] ch, input logic is_last);
        out_item_t c;
        c.char_out  = ch;
        c.last_char = is_last;
        expected_chars.push_back(c);
    endfunction

    // Works out the characters that one accepted byte gives. The byte is
    // either held, or it closes a group. A group is closed by its third
    // byte, or by a last byte that ends a partial group. Only a partial
    // group is padded. The final character of each run is marked, and the
    // position then goes back to the start of a group.
    function automatic void encode_byte(input in_item_t item);
        logic [7:0] b;
        b = item.data_byte;
        case (group_pos)
            GRP_ONE:
            begin
                if (!item.last_byte)
                begin
                    held_second = b;
                    group_pos   = GRP_TWO;
                end
                else
                begin
                    owe_char(sextet_char(held_first[7:2]), 1'b0);
                    owe_char(sextet_char({held_first[1:0], b[7:4]}), 1'b0);
                    owe_char(sextet_char({b[3:0], 2'b00}), !pad_en);
                    if (pad_en)
                    begin
                        owe_char(CHAR_PAD, 1'b1);
                    end
                    group_pos = GRP_START;
                end
            end
            GRP_TWO:
            begin
                // The third byte always completes the group, whether or
                // not it is marked last.
                owe_char(sextet_char(held_first[7:2]), 1'b0);
                owe_char(sextet_char({held_first[1:0], held_second[7:4]}), 1'b0);
                owe_char(sextet_char({held_second[3:0], b[7:6]}), 1'b0);
                owe_char(sextet_char(b[5:0]), 1'b1);
                group_pos = GRP_START;
            end
            default:
            begin
                if (!item.last_byte)
                begin
                    held_first = b;
                    group_pos  = GRP_ONE;
                end
                else
                begin
                    owe_char(sextet_char(b[7:2]), 1'b0);
                    owe_char(sextet_char({b[1:0], 4'h0}), !pad_en);
                    if (pad_en)
                    begin
                        owe_char(CHAR_PAD, 1'b0);
                        owe_char(CHAR_PAD, 1'b1);
                    end
                    group_pos = GRP_START;
                end
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------

    // Offers one byte and returns at the edge where it is accepted. Valid is
    // left high on return. The next call either keeps it high with a new
    // payload or lowers it for a gap, so that valid is never lowered and
    // raised again in the same step.
    task automatic send_byte(input logic [7:0] data, input logic is_last);
        int gap;
        in_item_t item;
        gap = 0;
        // Each cycle is idle with the same chance, so that about a third of
        // the sender's cycles are gaps.
        while (sender_idles && ($urandom_range(99) < IDLE_PERCENT))
        begin
            gap++;
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item.data_byte = data;
        item.last_byte = is_last;
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        encode_byte(item);
        bytes_sent++;
        if (is_last)
        begin
            messages_sent++;
        end
    endtask

    // Sends a message of random bytes, and marks its final byte as last.
    task automatic send_message(input int len);
        for (int i = 0; i < len; i++)
        begin
            send_byte(8'($urandom_range(255)), i == len - 1);
        end
    endtask

    // Lowers valid, then waits until every owed character has arrived and
    // the encoder has had time to settle.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_chars.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // The padding register is only written while the encoder is idle.
    task automatic write_padding(input logic enable);
        drain_results();
        cfg_write_en   <= 1'b1;
        cfg_write_data <= enable;
        @(posedge clk);
        cfg_write_en   <= 1'b0;
        pad_en = enable;
    endtask

    task automatic send_random_messages(input int n_bytes);
        int sent;
        int len;
        sent = 0;
        while (sent < n_bytes)
        begin
            // Most messages are short, so that group ends and padding come
            // up often. Now and then a longer one runs many full groups.
            if ($urandom_range(9) == 0)
            begin
                len = $urandom_range(10, 30);
            end
            else
            begin
                len = $urandom_range(1, 8);
            end
            send_message(len);
            sent += len;
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Padding is on from reset. These items cover the extreme bytes, the
    // two sextets that map to '+' and '/', and each way of ending a group.
    // A group can end on one last byte, on two bytes, or on a third byte
    // with or without the last mark.
    task automatic test_directed_groups();
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h4D, 1'b0);
        send_byte(8'h61, 1'b1);
        send_byte(8'h4D, 1'b0);
        send_byte(8'h61, 1'b0);
        send_byte(8'h6E, 1'b0);
        send_byte(8'hFB, 1'b0);
        send_byte(8'hEF, 1'b0);
        send_byte(8'hBE, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b1);
        // A message of five bytes: one full group, then a partial one.
        send_byte(8'h80, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'hAA, 1'b1);
    endtask

    // With padding off, a partial group ends on its last data character.
    task automatic test_padding_off();
        write_padding(1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h10, 1'b1);
        send_random_messages(150);
    endtask

    task automatic test_padding_on();
        write_padding(1'b1);
        send_random_messages(150);
    endtask

    // A long stretch with no gaps on either side. Full groups then stream
    // at the rate of the output side.
    task automatic test_no_idling();
        drain_results();
        sender_idles    = 1'b0;
        receiver_stalls = 1'b0;
        send_random_messages(60);
        sender_idles    = 1'b1;
        receiver_stalls = 1'b1;
    endtask

    // The receiver holds off for a long time while bytes keep coming. The
    // queue fills, and in_ready has to drop without any character being
    // lost.
    task automatic test_back_pressure();
        drain_results();
        sender_idles = 1'b0;
        hold_request = 80;
        send_message(30);
        sender_idles = 1'b1;
    endtask

    // The sender stops partway through a message until every owed character
    // has come out. The held bytes must survive the pause.
    task automatic test_drain_pause();
        drain_results();
        send_byte(8'($urandom_range(255)), 1'b0);
        send_byte(8'($urandom_range(255)), 1'b0);
        send_byte(8'($urandom_range(255)), 1'b0);
        send_byte(8'($urandom_range(255)), 1'b0);
        drain_results();
        send_byte(8'($urandom_range(255)), 1'b0);
        send_byte(8'($urandom_range(255)), 1'b1);
        send_byte(8'($urandom_range(255)), 1'b0);
        drain_results();
        send_byte(8'($urandom_range(255)), 1'b1);
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_groups();
        test_padding_off();
        test_padding_on();
        test_no_idling();
        test_back_pressure();
        test_drain_pause();

        drain_results();
        repeat (END_CYCLES) @(posedge clk);

        $display("Encoded %0d bytes in %0d messages, %0d characters checked.",
                 bytes_sent, messages_sent, chars_checked);
        $display("Padding on and off, random gaps, a long hold-off (%0d input stalls).",
                 input_stalls);
        if (mismatch_count == 0)
        begin
            $display("base64_stream_encoder_test: done, clean");
        end
        else
        begin
            $display("base64_stream_encoder_test: done, errors");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver, result checker and watchdog
    // ------------------------------------------------------------------

    // This process drives out_ready. A hold-off request takes priority over
    // the random stalls.
    always @(posedge clk)
    begin : receiver_ready
        int hold_left;
        if (hold_request > 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (receiver_stalls)
        begin
            out_ready <= ($urandom_range(99) >= IDLE_PERCENT);
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // Every character accepted here is checked against the oldest owed one.
    always @(posedge clk)
    begin : result_checker
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_chars.size() == 0)
            begin
                $error("char_out: expected none, actual %h (last_char %b)",
                       out_data.char_out, out_data.last_char);
                mismatch_count++;
            end
            else
            begin
                want = expected_chars.pop_front();
                chars_checked++;
                if (out_data.char_out !== want.char_out)
                begin
                    $error("char_out: expected %h, actual %h",
                           want.char_out, out_data.char_out);
                    mismatch_count++;
                end
                if (out_data.last_char !== want.last_char)
                begin
                    $error("last_char: expected %b, actual %b",
                           want.last_char, out_data.last_char);
                    mismatch_count++;
                end
            end
        end
    end

    // Counts cycles for the time limit. It also counts the cycles in which
    // the encoder refused an offered byte.
    always @(posedge clk)
    begin : watchdog
        cycle_count++;
        if (rst_n && in_valid && !in_ready)
        begin
            input_stalls++;
        end
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("base64_stream_encoder_test: done, errors");
            $finish;
        end
    end

endmodule

`default_nettype wire
